>>> rtl/core/bpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types, widths and the prefix code table of the bit packer.
// ----------------------------------------------------------------------------
package bpk_pkg;

  localparam int SymW     = 8;
  localparam int ByteW    = 8;
  localparam int CodeW    = 12;              // longest code in the table
  localparam int LenW     = 4;
  localparam int PendW    = 7;               // at most seven bits stay behind
  localparam int PendCntW = 3;
  localparam int AccW     = PendW + CodeW;   // 19
  localparam int TotW     = 5;               // holds 0..19
  localparam int AlignW   = 24;              // three bytes
  localparam int BytesMax = 3;
  localparam int CntW     = 2;               // holds 0..3

  localparam logic [SymW-1:0] CharLowerA = 8'h61;
  localparam logic [SymW-1:0] CharLowerZ = 8'h7A;
  localparam logic [SymW-1:0] CharSpace  = 8'h20;
  localparam logic [SymW-1:0] CharBang   = 8'h21;

  typedef struct packed {
    logic [CodeW-1:0] code;   // right aligned
    logic [LenW-1:0]  len;    // zero for characters outside the table
  } code_entry_t;

  // A looked-up character, as held in the input register.
  typedef struct packed {
    code_entry_t entry;
    logic        eom;
  } code_item_t;

  // Bytes that one character releases, first byte to send in slot 0.
  typedef struct packed {
    logic [BytesMax-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                count;
    logic                           last;
  } pack_result_t;

  localparam code_entry_t LetterCodes [26] = '{
    '{12'd3,  4'd3},  '{12'd2,  4'd7},  '{12'd5,  4'd6},  '{12'd5,  4'd5},
    '{12'd5,  4'd3},  '{12'd4,  4'd6},  '{12'd4,  4'd7},  '{12'd3,  4'd4},
    '{12'd9,  4'd5},  '{12'd1,  4'd9},  '{12'd1,  4'd10}, '{12'd9,  4'd6},
    '{12'd3,  4'd6},  '{12'd16, 4'd5},  '{12'd17, 4'd5},  '{12'd5,  4'd7},
    '{12'd1,  4'd12}, '{12'd8,  4'd5},  '{12'd5,  4'd4},  '{12'd9,  4'd4},
    '{12'd3,  4'd5},  '{12'd1,  4'd8},  '{12'd3,  4'd7},  '{12'd1,  4'd11},
    '{12'd1,  4'd7},  '{12'd0,  4'd12}
  };

  localparam code_entry_t SpaceCode = '{12'd3, 4'd2};
  localparam code_entry_t BangCode  = '{12'd8, 4'd6};
  localparam code_entry_t NoCode    = '{12'd0, 4'd0};

  function automatic code_entry_t lookup_code(input logic [SymW-1:0] sym);
    code_entry_t     e;
    logic [SymW-1:0] off;
    off = sym - CharLowerA;
    e   = NoCode;
    if (sym >= CharLowerA && sym <= CharLowerZ) begin
      e = LetterCodes[off[4:0]];
    end else if (sym == CharSpace) begin
      e = SpaceCode;
    end else if (sym == CharBang) begin
      e = BangCode;
    end
    return e;
  endfunction

endpackage

>>> rtl/core/bpk_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_lookup
// Input register stage: takes a character request and holds its table code.
// ----------------------------------------------------------------------------
module bpk_lookup (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bpk_pkg::SymW-1:0]   s_axis_tdata,   // [7:0] symbol
  input  logic                       s_axis_tlast,   // end_of_message
  input  logic                       advance,
  output logic                       item_valid,
  output bpk_pkg::code_item_t        item
);
  import bpk_pkg::*;

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.entry <= lookup_code(s_axis_tdata);
      item.eom   <= s_axis_tlast;
    end
  end

endmodule

>>> rtl/core/bpk_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_pack
// Bit accumulator: appends a code to the pending bits and cuts out bytes.
// ----------------------------------------------------------------------------
module bpk_pack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  bpk_pkg::code_item_t   item,
  output bpk_pkg::pack_result_t result
);
  import bpk_pkg::*;

  logic [PendW-1:0]    pending_bits;
  logic [PendCntW-1:0] pending_count;
  logic [PendW-1:0]    pending_bits_next;
  logic [PendCntW-1:0] pending_count_next;

  logic [AccW-1:0]   acc;
  logic [TotW-1:0]   total;
  logic [TotW-1:0]   shamt;
  logic [AlignW-1:0] aligned;
  logic [PendW-1:0]  keep_mask;
  logic [CntW-1:0]   full_bytes;
  logic              partial;

  always_comb begin
    acc   = (AccW'(pending_bits) << item.entry.len) | AccW'(item.entry.code);
    total = TotW'(pending_count) + TotW'(item.entry.len);
    // Left aligning the bits in three bytes gives the flush padding for free.
    shamt   = TotW'(AlignW) - total;
    aligned = AlignW'(acc) << shamt;

    full_bytes = total[TotW-1:3];
    partial    = total[2:0] != 3'd0;

    result.bytes[0] = aligned[AlignW-1 -: ByteW];
    result.bytes[1] = aligned[AlignW-1-ByteW -: ByteW];
    result.bytes[2] = aligned[ByteW-1:0];
    result.count    = full_bytes + CntW'(item.eom && partial);
    result.last     = item.eom;

    keep_mask = PendW'((8'd1 << total[2:0]) - 8'd1);
    if (item.eom) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = acc[PendW-1:0] & keep_mask;
      pending_count_next = total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (load) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

>>> rtl/core/bpk_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_out_buf
// Result register: holds up to three bytes and sends them one per request.
// ----------------------------------------------------------------------------
module bpk_out_buf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bpk_pkg::pack_result_t       result,
  output logic                        ready,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bpk_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] code_byte
  output logic                        m_axis_tlast    // message_end
);
  import bpk_pkg::*;

  logic [BytesMax-1:0][ByteW-1:0] bytes;
  logic [CntW-1:0]                remaining;
  logic                           last;
  logic                           take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign ready         = (remaining == '0) || (remaining == CntW'(1) && m_axis_tready);
  assign m_axis_tvalid = remaining != '0;
  assign m_axis_tdata  = bytes[0];
  assign m_axis_tlast  = last && (remaining == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= result.count;
    end else if (take) begin
      remaining <= remaining - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= result.bytes;
      last  <= result.last;
    end else if (take) begin
      bytes[0] <= bytes[1];
      bytes[1] <= bytes[2];
    end
  end

endmodule

>>> rtl/core/prefix_code_bit_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core
// Prefix code encoder that packs code bits into a byte stream.
// ----------------------------------------------------------------------------
// Each request on the s_axis side is one character (tdata) with tlast marking
// the end of a message. The character's code is appended, most significant
// bit first, to a bit accumulator; every complete byte leaves on the m_axis
// side with the earliest bit in bit 7. On tlast, leftover bits are padded
// with zeros and sent, and the final byte carries tlast if the tlast character
// releases a byte. Characters outside the table add no bits.
// A character is looked up as it is accepted and held with its code in the
// input register; its bytes are cut out and held in the result register,
// which offers them. One character is taken every cycle as long as each
// releases at most one byte and the receiver does not stall; a character
// that releases two or three bytes holds the input while the result
// register sends them, one byte per cycle.
// The receiver may stall at any time: bytes wait in the result register and
// the input register, and tready falls once both are full.
// Reset clears the accumulator and drops any bytes not yet sent.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bpk_pkg::SymW-1:0]   s_axis_tdata,   // [7:0] symbol
  input  logic                       s_axis_tlast,   // end_of_message
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bpk_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] code_byte
  output logic                       m_axis_tlast    // message_end
);
  import bpk_pkg::*;

  logic         item_valid;
  code_item_t   item;
  pack_result_t result;
  logic         buf_ready;
  logic         load;

  assign load = item_valid && buf_ready;

  bpk_lookup u_lookup (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (buf_ready),
    .item_valid    (item_valid),
    .item          (item)
  );

  bpk_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .item   (item),
    .result (result)
  );

  bpk_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .result        (result),
    .ready         (buf_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
